// ===== rtl/geo_pkg.sv =====
`timescale 1ns / 1ps

package geo_pkg;

  localparam int MAX_NODES = 64;
  localparam int ROW_W     = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 7;
  localparam int BYTES     = ROW_W / 8;

  // Configuration register indexes
  localparam logic CFG_NODE_COUNT  = 1'b0;
  localparam logic CFG_ORIENT_MODE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ASC    = 2'd0,
    MODE_DESC   = 2'd1,
    MODE_DEGREE = 2'd2,
    MODE_CENTER = 2'd3
  } orient_mode_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DEGW,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } seq_state_t;

  // Degree write from the popcount pipeline
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [CNT_W-1:0] deg;
  } deg_wr_t;

  // Finished directed row offered to the output register
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic [ROW_W-1:0] bits;
    logic             last;
  } emit_t;

  // Clamp node count into 1..MAX_NODES
  function automatic logic [CNT_W-1:0] eff_nodes(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = n;
    if (n == '0) r = CNT_W'(1);
    else if (n > CNT_W'(MAX_NODES)) r = CNT_W'(MAX_NODES);
    return r;
  endfunction

  // Ones in the columns below n
  function automatic logic [ROW_W-1:0] col_mask(input logic [CNT_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int b = 0; b < ROW_W; b++) begin
      m[b] = (CNT_W'(b) < n);
    end
    return m;
  endfunction

  // Orientation of edge a-b with a < b: 1 means a -> b
  function automatic logic orient_fwd(input logic [MODE_W-1:0] mode,
                                      input logic [IDX_W-1:0]  a,
                                      input logic [IDX_W-1:0]  b,
                                      input logic [CNT_W-1:0]  da,
                                      input logic [CNT_W-1:0]  db,
                                      input logic [IDX_W-1:0]  c);
    logic f;
    case (orient_mode_t'(mode))
      MODE_DESC:   f = 1'b0;
      MODE_DEGREE: f = !(db < da);
      MODE_CENTER: begin
        if (b == c) f = 1'b1;
        else if (a == c) f = 1'b0;
        else if (a < c && b < c) f = 1'b1;
        else if (a > c && b > c) f = 1'b0;
        else if (a < c && b > c) f = 1'b1;
        else f = 1'b0;
      end
      default:     f = 1'b1;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/geo_degree.sv =====
`timescale 1ns / 1ps

module geo_degree import geo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_take,
  input  logic [IDX_W-1:0]     in_index,
  input  logic [ROW_W-1:0]     in_bits,
  input  logic [CNT_W-1:0]     n_eff,
  output deg_wr_t              deg_wr
);

  logic [ROW_W-1:0] masked;
  logic [3:0]       byte_cnt [BYTES];
  logic [3:0]       byte_q   [BYTES];
  logic [IDX_W-1:0] addr_q;
  logic             valid_q;
  logic [CNT_W-1:0] total;

  // Count set bits per byte of the masked row
  always_comb begin
    masked = in_bits & col_mask(n_eff);
    for (int g = 0; g < BYTES; g++) begin
      byte_cnt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        byte_cnt[g] = byte_cnt[g] + 4'(masked[g*8+b]);
      end
    end
  end

  // Register the byte counts with the row index and the take strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_take;
    end
    addr_q <= in_index;
    for (int g = 0; g < BYTES; g++) begin
      byte_q[g] <= byte_cnt[g];
    end
  end

  // Sum byte counts into the degree
  always_comb begin
    total = '0;
    for (int g = 0; g < BYTES; g++) begin
      total = total + CNT_W'(byte_q[g]);
    end
  end

  assign deg_wr.en   = valid_q;
  assign deg_wr.addr = addr_q;
  assign deg_wr.deg  = total;

endmodule

// ===== rtl/geo_seq.sv =====
`timescale 1ns / 1ps

module geo_seq import geo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IDX_W-1:0]     in_index,
  input  logic [ROW_W-1:0]     in_bits,
  input  logic                 in_last,
  input  deg_wr_t              deg_wr,
  input  logic [CNT_W-1:0]     n_eff,
  input  logic [MODE_W-1:0]    mode,
  input  logic                 out_take,
  output emit_t                emit
);

  seq_state_t       state, state_next;
  logic [ROW_W-1:0] adj_mem [MAX_NODES];
  logic [CNT_W-1:0] deg_mem [MAX_NODES];
  logic [ROW_W-1:0] adj_q;
  logic [CNT_W-1:0] deg_q;
  logic [IDX_W-1:0] adj_addr;
  logic [IDX_W-1:0] deg_addr;
  logic [IDX_W-1:0] row_i;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] k1;
  logic             v1;
  logic [CNT_W-1:0] deg_i;
  logic [ROW_W-1:0] acc;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] center;
  logic             in_take;
  logic             lower;
  logic [IDX_W-1:0] ea, eb;
  logic [CNT_W-1:0] eda, edb;
  logic             edge_on;
  logic             fwd;
  logic             new_bit;

  assign last_idx = IDX_W'(n_eff - CNT_W'(1));
  assign center   = IDX_W'(n_eff >> 1);
  assign in_take  = in_valid && in_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (in_take && in_last) state_next = ST_DEGW;
      ST_DEGW:  state_next = ST_PREP;
      ST_PREP:  state_next = ST_SCAN;
      ST_SCAN:  if (k == last_idx) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_take) state_next = (row_i == last_idx) ? ST_LOAD : ST_PREP;
      end
      default:  state_next = ST_LOAD;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready   = (state == ST_LOAD);
    emit.valid = (state == ST_EMIT);
    emit.index = row_i;
    emit.bits  = acc;
    emit.last  = (row_i == last_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Memory addresses: lower rows for the column part, row i for the rest
  assign adj_addr = (k < row_i) ? k : row_i;
  assign deg_addr = (state == ST_SCAN) ? k : row_i;

  // Adjacency and degree memories
  always_ff @(posedge clk) begin
    if (in_take) adj_mem[in_index] <= in_bits;
    if (deg_wr.en) deg_mem[deg_wr.addr] <= deg_wr.deg;
    adj_q <= adj_mem[adj_addr];
    deg_q <= deg_mem[deg_addr];
  end

  // Shared orientation unit: one edge per cycle while scanning
  always_comb begin
    lower   = (k1 < row_i);
    ea      = lower ? k1 : row_i;
    eb      = lower ? row_i : k1;
    eda     = lower ? deg_q : deg_i;
    edb     = lower ? deg_i : deg_q;
    edge_on = lower ? adj_q[row_i] : adj_q[k1];
    fwd     = orient_fwd(mode, ea, eb, eda, edb, center);
    new_bit = (k1 != row_i) && edge_on && (lower ? !fwd : fwd);
  end

  // Row counter, scan counter and accumulated directed row
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      row_i <= '0;
      k     <= '0;
    end else begin
      v1 <= (state == ST_SCAN);
      case (state)
        ST_LOAD: row_i <= '0;
        ST_PREP: k <= '0;
        ST_SCAN: k <= k + IDX_W'(1);
        ST_EMIT: if (out_take) row_i <= row_i + IDX_W'(1);
        default: ;
      endcase
    end
    k1 <= k;
    if (state == ST_SCAN && k == '0) deg_i <= deg_q;
    if (state == ST_PREP) acc <= '0;
    else if (v1) acc[k1] <= new_bit;
  end

`ifndef SYNTHESIS
  a_mask_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ((acc & ~col_mask(n_eff)) == '0))
    else $error("directed row has bits at or above node count");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> ({1'b0, k1} < n_eff))
    else $error("scan column beyond node count");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_take && row_i != last_idx)
      |=> (state == ST_PREP && row_i == $past(row_i) + IDX_W'(1)))
    else $error("row did not advance after emit");

  a_deg_write_window: assert property (@(posedge clk) disable iff (rst)
    deg_wr.en |-> (state == ST_LOAD || state == ST_DEGW))
    else $error("degree written during emission");
`endif

endmodule

// ===== rtl/graph_edge_orienter_core.sv =====
`timescale 1ns / 1ps
// Load: one row request per cycle, taken only in the load state and never while rows
// are emitted; a row's degree is written in the cycle after its request is taken.
// Emit: each directed row passes a prep state, a scan of its columns through the
// shared orientation unit and a drain state, then an emit state that waits until
// the output register is free to take it.
// Synchronous active-high reset clears control state, node_count 64, mode ascending.

module graph_edge_orienter_core import geo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [71:0]          s_tdata,   // row_index[5:0], row_bits[69:6], zero pad
  input  logic                 s_tlast,   // last_row
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [71:0]          m_tdata,   // out_row_index[5:0], out_row_bits[69:6], zero pad
  output logic                 m_tlast,   // out_last
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CNT_W-1:0]  node_count;
  logic [MODE_W-1:0] orient_mode;
  logic [CNT_W-1:0]  n_eff;
  logic              in_take;
  logic              out_take;
  deg_wr_t           deg_wr;
  emit_t             emit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= CNT_W'(MAX_NODES);
      orient_mode <= MODE_ASC;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT:  node_count  <= cfg_data;
        CFG_ORIENT_MODE: orient_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff   = eff_nodes(node_count);
  assign in_take = s_tvalid && s_tready;

  geo_degree u_degree (
    .clk      (clk),
    .rst      (rst),
    .in_take  (in_take),
    .in_index (s_tdata[5:0]),
    .in_bits  (s_tdata[69:6]),
    .n_eff    (n_eff),
    .deg_wr   (deg_wr)
  );

  geo_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_index (s_tdata[5:0]),
    .in_bits  (s_tdata[69:6]),
    .in_last  (s_tlast),
    .deg_wr   (deg_wr),
    .n_eff    (n_eff),
    .mode     (orient_mode),
    .out_take (out_take),
    .emit     (emit)
  );

  // Output register: take a finished row when empty or being drained
  assign out_take = emit.valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_take) begin
      m_tdata <= {2'b00, emit.bits, emit.index};
      m_tlast <= emit.last;
    end
  end

endmodule

// ===== dv/tb_graph_edge_orienter_core.sv =====
`timescale 1ns / 1ps

module tb_graph_edge_orienter_core;
  import geo_pkg::*;

  localparam int RANDOM_ROWS   = 135;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 5000;
  localparam int MAX_REPORTS   = 30;

  // One directed row as it leaves the block
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] bits;
    logic             last;
  } dir_row_t;

  typedef enum logic {STEP_CFG, STEP_ROW} step_kind_t;

  // Directed script line: a register write or a row request
  typedef struct packed {
    step_kind_t       kind;
    logic             sel;
    logic [CFG_W-1:0] val;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] bits;
    logic             last;
    logic             typed;
    logic [ROW_W-1:0] exp0;
    logic [ROW_W-1:0] exp1;
  } script_step_t;

  logic             clk;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [71:0]      s_tdata   = '0;   // row_index[5:0], row_bits[69:6], zero pad
  logic             s_tlast   = 1'b0; // last_row
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [71:0]      m_tdata;          // out_row_index[5:0], out_row_bits[69:6], zero pad
  logic             m_tlast;          // out_last
  logic             cfg_we    = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;

  // Graph store and settings as the block should hold them
  logic [ROW_W-1:0]     adj_mem [MAX_NODES];
  logic [CNT_W-1:0]     deg_mem [MAX_NODES];
  logic [CNT_W-1:0]     node_q;
  orient_mode_t         mode_q;
  logic [MAX_NODES-1:0] row_seen = '0;
  dir_row_t             pending_rows [$];

  int unsigned mismatches    = 0;
  int unsigned rows_checked  = 0;
  int unsigned directed_rows = 0;
  int unsigned random_rows   = 0;
  int unsigned graphs        = 0;
  int unsigned burst_left    = 0;
  int unsigned idle_cycles   = 0;
  bit          in_random     = 1'b0;

  graph_edge_orienter_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp the node count register into the usable range
  function automatic int node_span();
    if (node_q == '0) return 1;
    if (node_q > CNT_W'(MAX_NODES)) return MAX_NODES;
    return int'(node_q);
  endfunction

  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return a & b & {$urandom, $urandom};
      3: return a | b;
      default: return a;
    endcase
  endfunction

  function automatic script_step_t make_cfg(input logic sel, input logic [CFG_W-1:0] val);
    script_step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.sel = sel;
    s.val = val;
    return s;
  endfunction

  function automatic script_step_t make_row(input logic [IDX_W-1:0] idx,
                                            input logic [ROW_W-1:0] bits,
                                            input logic last, input logic typed,
                                            input logic [ROW_W-1:0] exp0,
                                            input logic [ROW_W-1:0] exp1);
    script_step_t s;
    s.kind = STEP_ROW;
    s.sel = 1'b0;
    s.val = '0;
    s.idx = idx;
    s.bits = bits;
    s.last = last;
    s.typed = typed;
    s.exp0 = exp0;
    s.exp1 = exp1;
    return s;
  endfunction

  task automatic report_fault(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  // Store a row with its degree; on the last row orient the graph and queue the rows
  task automatic orient_graph(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] bits,
                              input logic last, input logic typed,
                              input logic [ROW_W-1:0] exp0, input logic [ROW_W-1:0] exp1);
    logic [ROW_W-1:0] dir [MAX_NODES];
    logic [ROW_W-1:0] span_mask;
    dir_row_t         want;
    logic             fwd;
    int               n;
    int               c;
    n = node_span();
    span_mask = '0;
    for (int k = 0; k < n; k++) span_mask[k] = 1'b1;
    adj_mem[idx] = bits;
    deg_mem[idx] = CNT_W'($countones(bits & span_mask));
    if (last) begin
      c = n / 2;
      for (int i = 0; i < MAX_NODES; i++) dir[i] = '0;
      for (int i = 0; i < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          if (adj_mem[i][j]) begin
            case (mode_q)
              MODE_DESC:   fwd = 1'b0;
              MODE_DEGREE: fwd = (deg_mem[j] >= deg_mem[i]);
              MODE_CENTER: begin
                // Edges on the center point at it; others toward it, or up across it
                if (j == c) fwd = 1'b1;
                else if (i == c) fwd = 1'b0;
                else fwd = (i < c);
              end
              default:     fwd = 1'b1;
            endcase
            if (fwd) dir[i][j] = 1'b1;
            else dir[j][i] = 1'b1;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        want.idx = IDX_W'(i);
        want.bits = dir[i];
        if (typed) want.bits = (i == 0) ? exp0 : exp1;
        want.last = (i == n - 1);
        pending_rows.push_back(want);
      end
    end
  endtask

  // Offer one row request in bursts with random gaps, then predict on acceptance
  task automatic send_row(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] bits,
                          input logic last, input logic typed,
                          input logic [ROW_W-1:0] exp0, input logic [ROW_W-1:0] exp1);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, bits, idx};
    s_tlast  <= last;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    burst_left--;
    orient_graph(idx, bits, last, typed, exp0, exp1);
    row_seen[idx] = 1'b1;
    if (in_random) random_rows++;
    else directed_rows++;
    if (last) graphs++;
  endtask

  // Drop valid and wait until the block has drained
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (sel == CFG_NODE_COUNT) node_q = val;
    else mode_q = orient_mode_t'(val[MODE_W-1:0]);
  endtask

  // Random graph: fill unwritten rows in range (at times all), add noise rows, shuffle
  task automatic run_graph();
    logic [IDX_W-1:0] order [$];
    logic [IDX_W-1:0] tmp;
    int               n;
    int               k;
    int               pick;
    n = node_span();
    if (n <= 16 && $urandom_range(0, 2) == 0) begin
      for (k = 0; k < n; k++) order.push_back(IDX_W'(k));
    end else begin
      for (k = 0; k < n; k++) if (!row_seen[k]) order.push_back(IDX_W'(k));
    end
    pick = $urandom_range(1, 6);
    for (k = 0; k < pick; k++) order.push_back(IDX_W'($urandom_range(0, MAX_NODES - 1)));
    for (k = order.size() - 1; k > 0; k--) begin
      pick = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[pick];
      order[pick] = tmp;
    end
    for (k = 0; k < order.size(); k++) begin
      send_row(order[k], random_row(), (k == order.size() - 1), 1'b0, '0, '0);
    end
  endtask

  // Compare each accepted directed row with the oldest expectation
  always @(negedge clk) begin : row_checker
    dir_row_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_rows.size() == 0) begin
        report_fault($sformatf("unexpected row: expected none, got index %0d bits %h",
                               m_tdata[5:0], m_tdata[69:6]));
      end else begin
        want = pending_rows.pop_front();
        if (m_tdata[5:0] !== want.idx)
          report_fault($sformatf("out_row_index: expected %0d, got %0d",
                                 want.idx, m_tdata[5:0]));
        if (m_tdata[69:6] !== want.bits)
          report_fault($sformatf("out_row_bits of row %0d: expected %h, got %h",
                                 want.idx, want.bits, m_tdata[69:6]));
        if (m_tlast !== want.last)
          report_fault($sformatf("out_last of row %0d: expected %0b, got %0b",
                                 want.idx, want.last, m_tlast));
        rows_checked++;
      end
    end
  end

  // Stall the output on a pattern; once, hold off long while input is offered
  initial begin : sink_pattern
    int unsigned seg_left;
    int unsigned style;
    bit          hold_now;
    bit          pressure_done;
    seg_left = 0;
    style = 0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      hold_now = !pressure_done && in_random && s_tvalid && m_tvalid;
      @(posedge clk);
      if (hold_now) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          style = $urandom_range(0, 2);
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (style)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // End the run when no request moves for too long
  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no request accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    script_step_t script [$];
    orient_mode_t md;
    int           nc;
    int           frame;
    int           big_left;

    node_q = CNT_W'(MAX_NODES);
    mode_q = MODE_ASC;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Single node: self loops never show up; zero count acts as one
    script.push_back(make_cfg(CFG_NODE_COUNT, 7'd1));
    script.push_back(make_row(6'd0, '1, 1'b1, 1'b1, '0, '0));
    script.push_back(make_cfg(CFG_NODE_COUNT, 7'd0));
    script.push_back(make_row(6'd63, '1, 1'b0, 1'b0, '0, '0));
    script.push_back(make_row(6'd0, '0, 1'b1, 1'b1, '0, '0));
    // Two nodes, one edge, each orientation
    script.push_back(make_cfg(CFG_NODE_COUNT, 7'd2));
    script.push_back(make_row(6'd0, 64'h2, 1'b0, 1'b0, '0, '0));
    script.push_back(make_row(6'd1, 64'h1, 1'b1, 1'b1, 64'h2, 64'h0));
    script.push_back(make_cfg(CFG_ORIENT_MODE, CFG_W'(MODE_DESC)));
    script.push_back(make_row(6'd1, 64'h1, 1'b1, 1'b1, 64'h0, 64'h1));
    script.push_back(make_cfg(CFG_ORIENT_MODE, CFG_W'(MODE_DEGREE)));
    script.push_back(make_row(6'd0, '1, 1'b0, 1'b0, '0, '0));
    script.push_back(make_row(6'd1, 64'h1, 1'b1, 1'b1, 64'h0, 64'h1));
    script.push_back(make_cfg(CFG_ORIENT_MODE, CFG_W'(MODE_CENTER)));
    script.push_back(make_row(6'd1, 64'h1, 1'b1, 1'b1, 64'h2, 64'h0));
    // Five nodes with dense, empty and alternating rows
    script.push_back(make_cfg(CFG_NODE_COUNT, 7'd5));
    script.push_back(make_row(6'd2, '1, 1'b0, 1'b0, '0, '0));
    script.push_back(make_row(6'd3, '0, 1'b0, 1'b0, '0, '0));
    script.push_back(make_row(6'd4, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0, '0));
    script.push_back(make_row(6'd0, 64'h5555_5555_5555_5555, 1'b0, 1'b0, '0, '0));
    script.push_back(make_row(6'd1, '1, 1'b1, 1'b0, '0, '0));
    script.push_back(make_cfg(CFG_ORIENT_MODE, CFG_W'(MODE_DEGREE)));
    script.push_back(make_row(6'd3, 64'h8000_0000_0000_0016, 1'b1, 1'b0, '0, '0));

    foreach (script[k]) begin
      if (script[k].kind == STEP_CFG) begin
        settle();
        write_reg(script[k].sel, script[k].val);
      end else begin
        send_row(script[k].idx, script[k].bits, script[k].last, script[k].typed,
                 script[k].exp0, script[k].exp1);
      end
    end

    // Random graphs; some follow back to back with no settings change
    in_random = 1'b1;
    frame = 0;
    big_left = 1;
    while (random_rows < RANDOM_ROWS) begin
      if (frame < 3 || (frame != 4 && $urandom_range(0, 1) == 1)) begin
        settle();
        if (frame == 0) begin
          nc = MAX_NODES;
          md = MODE_DEGREE;
        end else if (frame == 1) begin
          nc = 127;
          md = MODE_CENTER;
        end else if (frame == 2) begin
          nc = 0;
          md = MODE_DESC;
        end else begin
          md = orient_mode_t'(MODE_W'($urandom_range(0, 3)));
          case ($urandom_range(0, 9))
            0: nc = 1;
            1: begin
              if (big_left > 0) begin
                nc = $urandom_range(65, 126);
                big_left--;
              end else begin
                nc = 3;
              end
            end
            2, 3: nc = $urandom_range(11, 30);
            default: nc = $urandom_range(2, 10);
          endcase
        end
        write_reg(CFG_NODE_COUNT, CFG_W'(nc));
        write_reg(CFG_ORIENT_MODE, CFG_W'(md));
      end
      run_graph();
      frame++;
    end

    settle();
    repeat (32) @(posedge clk);
    $display("Sent %0d directed and %0d random row requests forming %0d graphs; %0d rows checked",
             directed_rows, random_rows, graphs, rows_checked);
    $display("Covered node counts 0, 1, full and above range, all four modes, one long stall");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/geo_pkg.sv
rtl/geo_degree.sv
rtl/geo_seq.sv
rtl/graph_edge_orienter_core.sv
dv/tb_graph_edge_orienter_core.sv
